// File: src/dws_pkg.sv
// shared types and codes for the double-ended queue with sort
package dws_pkg;

  localparam int DATA_W  = 32;
  localparam int OP_W    = 3;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 7;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_BACK  = 3'd5,
    OP_SORT_UP    = 3'd6,
    OP_SORT_DOWN  = 3'd7
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

// File: src/dws_in_if.sv
// request channel: operation and value
interface dws_in_if import dws_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink (input valid, input operation, input value, output ready);
endinterface

// File: src/dws_out_if.sv
// result channel: data, status and count
interface dws_out_if import dws_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] data;
  logic [STAT_W-1:0]        status;
  logic [COUNT_W-1:0]       count;

  modport source (output valid, output data, output status, output count, input ready);
  modport sink (input valid, input data, input status, input count, output ready);
endinterface

// File: src/dws_mem.sv
// ring storage: one write port, one read port with registered read data
module dws_mem import dws_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic signed [DATA_W-1:0] wdata,
  input  logic [AW-1:0]            raddr,
  output logic signed [DATA_W-1:0] rdata
);

  logic signed [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/dws_ctrl.sv
// request sequencer, ring pointers and bubble sort walker
module dws_ctrl import dws_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                     clk,
  input  logic                     rst,
  dws_in_if.sink                   in,
  dws_out_if.source                out,
  output logic                     mem_we,
  output logic [AW-1:0]            mem_waddr,
  output logic signed [DATA_W-1:0] mem_wdata,
  output logic [AW-1:0]            mem_raddr,
  input  logic signed [DATA_W-1:0] mem_rdata
);

  localparam int FW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_PRIME,
    S_STEP,
    S_TAIL,
    S_RESP
  } state_t;

  state_t                   state;
  logic [AW-1:0]            head;
  logic [FW-1:0]            fill;
  logic [AW-1:0]            pass_end;
  logic [AW-1:0]            rd_pos;
  logic signed [DATA_W-1:0] carry;
  logic                     swapped;
  logic                     desc;
  logic signed [DATA_W-1:0] res_data;
  status_t                  res_status;

  op_t           op;
  logic          accept;
  logic          is_full;
  logic          is_empty;
  logic          swap;
  logic [AW-1:0] head_dec;
  logic [AW-1:0] head_inc;
  logic [AW-1:0] back_slot;

  // ring position to memory slot
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base, input logic [AW-1:0] pos);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, pos};
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign op       = op_t'(in.operation);
  assign in.ready = (state == S_IDLE);
  assign accept   = in.valid && in.ready;
  assign is_full  = (fill == FW'(DEPTH));
  assign is_empty = (fill == '0);
  assign head_dec = (head == '0) ? AW'(DEPTH - 1) : head - 1'b1;
  assign head_inc = (head == AW'(DEPTH - 1)) ? '0 : head + 1'b1;
  assign back_slot = slot(head, AW'(fill - 1'b1));
  assign swap     = desc ? (mem_rdata > carry) : (carry > mem_rdata);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = head;
    mem_wdata = in.value;
    mem_raddr = head;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (op)
            OP_PUSH_FRONT: begin
              mem_we    = !is_full;
              mem_waddr = head_dec;
            end
            OP_PUSH_BACK: begin
              mem_we    = !is_full;
              mem_waddr = slot(head, AW'(fill));
            end
            OP_POP_BACK, OP_PEEK_BACK: mem_raddr = back_slot;
            default: mem_raddr = head;
          endcase
        end
      end
      S_STEP: begin
        mem_raddr = slot(head, rd_pos + 1'b1);
        if (rd_pos != '0) begin
          mem_we    = 1'b1;
          mem_waddr = slot(head, rd_pos - 1'b1);
          mem_wdata = swap ? mem_rdata : carry;
        end
      end
      S_TAIL: begin
        mem_we    = 1'b1;
        mem_waddr = slot(head, pass_end);
        mem_wdata = carry;
      end
      default: mem_raddr = head;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      fill      <= '0;
      out.valid <= 1'b0;
    end else begin
      // a beat taken while the next one loads is handled in S_RESP
      if (out.valid && out.ready && state != S_RESP) begin
        out.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            res_data   <= '0;
            res_status <= ST_OK;
            desc       <= (op == OP_SORT_DOWN);
            state      <= S_RESP;
            case (op)
              OP_PUSH_FRONT: begin
                if (is_full) begin
                  res_status <= ST_FULL;
                end else begin
                  head <= head_dec;
                  fill <= fill + 1'b1;
                end
              end
              OP_PUSH_BACK: begin
                if (is_full) begin
                  res_status <= ST_FULL;
                end else begin
                  fill <= fill + 1'b1;
                end
              end
              OP_POP_FRONT: begin
                if (is_empty) begin
                  res_status <= ST_EMPTY;
                end else begin
                  head  <= head_inc;
                  fill  <= fill - 1'b1;
                  state <= S_READ;
                end
              end
              OP_POP_BACK: begin
                if (is_empty) begin
                  res_status <= ST_EMPTY;
                end else begin
                  fill  <= fill - 1'b1;
                  state <= S_READ;
                end
              end
              OP_PEEK_FRONT, OP_PEEK_BACK: begin
                if (is_empty) begin
                  res_status <= ST_EMPTY;
                end else begin
                  state <= S_READ;
                end
              end
              OP_SORT_UP, OP_SORT_DOWN: begin
                if (fill >= FW'(2)) begin
                  pass_end <= AW'(fill - 1'b1);
                  state    <= S_PRIME;
                end
              end
              default: state <= S_RESP;
            endcase
          end
        end
        S_READ: begin
          res_data <= mem_rdata;
          state    <= S_RESP;
        end
        S_PRIME: begin
          rd_pos  <= '0;
          swapped <= 1'b0;
          state   <= S_STEP;
        end
        S_STEP: begin
          // carry holds the value bubbling toward the end of the pass
          if (rd_pos == '0) begin
            carry <= mem_rdata;
          end else begin
            carry <= swap ? carry : mem_rdata;
            if (swap) begin
              swapped <= 1'b1;
            end
          end
          if (rd_pos == pass_end) begin
            state <= S_TAIL;
          end else begin
            rd_pos <= rd_pos + 1'b1;
          end
        end
        S_TAIL: begin
          if (pass_end == AW'(1) || !swapped) begin
            state <= S_RESP;
          end else begin
            pass_end <= pass_end - 1'b1;
            state    <= S_PRIME;
          end
        end
        S_RESP: begin
          if (!out.valid || out.ready) begin
            out.valid  <= 1'b1;
            out.data   <= res_data;
            out.status <= res_status;
            out.count  <= COUNT_W'(fill);
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: src/deque_with_sort_top.sv
// top level of the double-ended queue with in-place stable sort
// push: the accepting state goes straight to the result load; pop and peek pass through a
// read state for the registered memory read; one request in flight at a time
// sort of n >= 2 values: bubble passes over the ring memory with one write and one read
// port, each pass one shorter than the last, with early exit when a pass swaps nothing;
// reset clears head, count and the output beat, no memory pass
module deque_with_sort_top import dws_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst,
  dws_in_if.sink    in,
  dws_out_if.source out
);

  // ring index width; count width follows inside the sequencer
  localparam int AW = $clog2(DEPTH);

  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic signed [DATA_W-1:0] mem_wdata;
  logic [AW-1:0]            mem_raddr;
  logic signed [DATA_W-1:0] mem_rdata;

  // sequencer: owns head and fill, the handshakes and the sort walk
  dws_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in        (in),
    .out       (out),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // value storage, read data registered in the cycle after the address
  dws_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// File: src/dws_checker.sv
// port-level checks of the queue, bound to the top level
module dws_checker import dws_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [DATA_W-1:0] out_data,
  input logic [STAT_W-1:0]        out_status,
  input logic [COUNT_W-1:0]       out_count
);

  // a stalled result beat stays
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // no unused status code
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_status != 2'd3)
    else $error("undefined status code");

  // failed requests carry zero data
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != ST_OK |-> out_data == '0)
    else $error("nonzero data on failed request");

  // an empty report means nothing is stored
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == ST_EMPTY |-> out_count == '0)
    else $error("empty status with nonzero count");

endmodule

bind deque_with_sort_top dws_checker u_dws_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out.valid),
  .out_ready  (out.ready),
  .out_data   (out.data),
  .out_status (out.status),
  .out_count  (out.count)
);
